@@ rtl/sorted_multiset_linked_table_defines.svh @@
// assertion macros shared by the checker of the sorted multiset table
`ifndef SORTED_MULTISET_LINKED_TABLE_DEFINES_SVH
`define SORTED_MULTISET_LINKED_TABLE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define SMLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smlt: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define SMLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smlt: next-cycle check failed");

`endif

@@ rtl/smlt_pkg.sv @@
// types and constants shared by the sorted multiset table modules
`default_nettype none

package smlt_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned IN_VAL_W    = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned RES_W       = 1 + CNT_W + CNT_W + 1;
  localparam int unsigned RES_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_START,
    ST_WALK,
    ST_LINK_A,
    ST_LINK_B,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic load_req;
    logic pop_en;
    logic start_en;
    logic step_en;
    logic commit_a;
    logic commit_b;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic head_null;
    logic advance;
    logic last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/smlt_ctrl.sv @@
// sequencer for the sorted multiset table: clear pass, dispatch, walk, relink
`default_nettype none

module smlt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire smlt_pkg::sts_t sts_i,
  output smlt_pkg::cmd_t     cmd_o
);
  import smlt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts_i.op == OP_ADD && sts_i.full) state_d = ST_DONE;
        else state_d = ST_START;
      end
      ST_START: begin
        if (!sts_i.head_null) state_d = ST_WALK;
        else if (sts_i.op == OP_ADD) state_d = ST_LINK_A;
        else state_d = ST_DONE;
      end
      ST_WALK: begin
        if (sts_i.advance && !sts_i.last) begin
          state_d = ST_WALK;
        end else begin
          unique case (sts_i.op)
            OP_ADD:    state_d = ST_LINK_A;
            OP_REMOVE: state_d = sts_i.advance ? ST_DONE : ST_LINK_A;
            OP_SEARCH: state_d = ST_DONE;
            OP_COUNT:  state_d = ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_LINK_A: state_d = ST_LINK_B;
      ST_LINK_B: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ST_DISPATCH: cmd_o.pop_en   = (sts_i.op == OP_ADD) && !sts_i.full;
      ST_START:    cmd_o.start_en = 1'b1;
      ST_WALK:     cmd_o.step_en  = 1'b1;
      ST_LINK_A:   cmd_o.commit_a = 1'b1;
      ST_LINK_B:   cmd_o.commit_b = 1'b1;
      ST_DONE:     cmd_o.out_load = sts_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/smlt_datapath.sv @@
// node store, list pointers, walk registers and result register of the table
`default_nettype none

module smlt_datapath #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire smlt_pkg::cmd_t                    cmd_i,
  output smlt_pkg::sts_t                         sts_o,
  input  wire logic [smlt_pkg::MODE_W-1:0]       in_mode_i,
  input  wire logic [smlt_pkg::IN_VAL_W-1:0]     in_value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_desc_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [smlt_pkg::RES_TDATA_W-1:0]       out_data_o
);
  import smlt_pkg::*;

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW    = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W = (VALUE_WIDTH > IN_VAL_W) ? VALUE_WIDTH : IN_VAL_W;
  localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);
  localparam logic [LW-1:0] LAST_STEP = LW'(CAPACITY - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  // node store
  logic signed [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic        [LW-1:0]          link_mem [CAPACITY];

  logic signed [VALUE_WIDTH-1:0] val_rd_q;
  logic        [LW-1:0]          link_rd_q;
  logic        [AW-1:0]          rd_addr;
  logic                          link_we;
  logic        [AW-1:0]          link_waddr;
  logic        [LW-1:0]          link_wdata;

  // request and list state
  op_e                           op_q;
  logic signed [VALUE_WIDTH-1:0] e_q;
  logic [EXT_W-1:0]              in_ext;
  logic                          desc_q;
  logic [LW-1:0]                 head_q, free_head_q, count_q;
  logic [LW-1:0]                 cur_q, prev_q, steps_q, next_q, node_q;
  logic [AW-1:0]                 clr_q;
  logic                          ok_q;
  logic [CNT_W-1:0]              occ_q;
  logic                          out_valid_q;
  logic [RES_TDATA_W-1:0]        out_data_q;

  logic equal, in_order, advance, prev_null;
  logic [LW-1:0] relink;

  assign in_ext = EXT_W'(in_value_i);

  always_comb begin
    unique case (1'b1)
      cmd_i.start_en: rd_addr = head_q[AW-1:0];
      cmd_i.step_en:  rd_addr = link_rd_q[AW-1:0];
      default:        rd_addr = free_head_q[AW-1:0];
    endcase
  end

  assign equal     = (val_rd_q == e_q);
  assign in_order  = desc_q ? (val_rd_q >= e_q) : (val_rd_q <= e_q);
  assign prev_null = (prev_q >= LINK_NULL);
  assign relink    = (op_q == OP_ADD) ? node_q : next_q;

  always_comb begin
    unique case (op_q)
      OP_ADD:    advance = in_order;
      OP_REMOVE: advance = !equal;
      OP_SEARCH: advance = !equal;
      OP_COUNT:  advance = 1'b1;
      default:   advance = 1'b1;
    endcase
  end

  // one write port on the link store
  always_comb begin
    link_we    = 1'b0;
    link_waddr = clr_q;
    link_wdata = LW'(clr_q) + LW'(1);
    priority if (cmd_i.clear_en) begin
      link_we = 1'b1;
    end else if (cmd_i.commit_a) begin
      link_we = 1'b1;
      if (op_q == OP_ADD) begin
        link_waddr = node_q[AW-1:0];
        link_wdata = cur_q;
      end else begin
        link_waddr = cur_q[AW-1:0];
        link_wdata = free_head_q;
      end
    end else if (cmd_i.commit_b) begin
      link_we    = !prev_null;
      link_waddr = prev_q[AW-1:0];
      link_wdata = relink;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cmd_i.pop_en) val_mem[free_head_q[AW-1:0]] <= e_q;
    link_rd_q <= link_mem[rd_addr];
    val_rd_q  <= val_mem[rd_addr];
  end

  // request payload and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q <= op_e'(in_mode_i);
      e_q  <= in_ext[VALUE_WIDTH-1:0];
    end
    if (cmd_i.pop_en) node_q <= free_head_q;
    if (cmd_i.start_en) begin
      cur_q   <= head_q;
      prev_q  <= LINK_NULL;
      steps_q <= '0;
    end else if (cmd_i.step_en) begin
      if (advance) begin
        prev_q  <= cur_q;
        cur_q   <= link_rd_q;
        steps_q <= steps_q + LW'(1);
      end else begin
        next_q <= link_rd_q;
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= RES_TDATA_W'({(count_q >= LINK_NULL), CNT_W'(count_q), occ_q, ok_q});
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q      <= 1'b0;
      head_q      <= LINK_NULL;
      free_head_q <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      ok_q        <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) desc_q <= cfg_desc_i;
      if (cmd_i.clear_en) clr_q <= clr_q + AW'(1);
      if (cmd_i.load_req) begin
        ok_q  <= 1'b0;
        occ_q <= '0;
      end
      if (cmd_i.pop_en) free_head_q <= link_rd_q;
      if (cmd_i.step_en && equal && op_q == OP_COUNT) occ_q <= occ_q + CNT_W'(1);
      if (cmd_i.step_en && !advance && op_q == OP_SEARCH) ok_q <= 1'b1;
      if (cmd_i.commit_a && op_q == OP_REMOVE) free_head_q <= cur_q;
      if (cmd_i.commit_b) begin
        ok_q <= 1'b1;
        if (prev_null) head_q <= relink;
        if (op_q == OP_ADD) count_q <= count_q + LW'(1);
        else count_q <= count_q - LW'(1);
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.full      = (count_q >= LINK_NULL) || (free_head_q >= LINK_NULL);
  assign sts_o.head_null = (head_q >= LINK_NULL);
  assign sts_o.advance   = advance;
  assign sts_o.last      = (link_rd_q >= LINK_NULL) || (steps_q == LAST_STEP);
  assign sts_o.clr_last  = (clr_q == LAST_ADDR);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/sorted_multiset_linked_table.sv @@
// top level of the sorted multiset table: linked list in a node store with a free list
//
//  channel   direction  payload (low bit first)                      transaction
//  s_axis    in         tdata: value[31:0]; tuser: mode[1:0]          tvalid & tready
//  m_axis    out        tdata: ok, occurrences[5:0], element_count[5:0],
//                              full_res, zero pad to 16 bits          tvalid & tready
//  cfg       in         cfg_data_i: descending                        cfg_valid_i & cfg_ready_o
//
//  one request at a time: accept, dispatch, start, a walk over the nodes to visit,
//    the relink steps LINK_A and LINK_B for an add and for a remove that finds its value,
//    then the load of the result register; an add to a full store skips to the load
//  after reset a clearing pass over every node builds the free chain; s_axis
//    stays not ready meanwhile, cfg writes are taken at any time
//  the result register lets the next request in while a result waits on m_axis;
//    the load cycle stalls until that result is taken
`default_nettype none

module sorted_multiset_linked_table #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [smlt_pkg::IN_VAL_W-1:0]       s_axis_tdata,  // value
  input  wire logic [smlt_pkg::MODE_W-1:0]         s_axis_tuser,  // mode
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // ok, occurrences, element_count, full_res, zero pad
  output logic [smlt_pkg::RES_TDATA_W-1:0]         m_axis_tdata,
  // order register write
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic                                cfg_data_i     // descending
);
  import smlt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // order register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  smlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // payload is latched on the accepting edge, under the controller's load command
  smlt_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_desc_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/smlt_checker.sv @@
// port-level checks of the sorted multiset table, bound to the top level
`default_nettype none
`include "sorted_multiset_linked_table_defines.svh"

module smlt_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a stalled result stays put
  `SMLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one request in flight: no second transaction on the next edge
  `SMLT_ASSERT_NEXT(a_one_inflight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a full store reports exactly capacity elements
  `SMLT_ASSERT_NOW(a_full_count, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[12:7] == 6'(CAPACITY))

  // only count mode reports occurrences, and count never reports ok
  `SMLT_ASSERT_NOW(a_ok_occ, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[6:1] == 6'd0)

endmodule

bind sorted_multiset_linked_table smlt_checker #(
  .CAPACITY (CAPACITY)
) u_smlt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
